>>> sv/dcdt_pkg.sv
package dcdt_pkg;

	// Table geometry: twelve months of 32 day slots each.
	localparam int TABLE_DEPTH = 384;
	localparam int ADDR_W      = 9;
	localparam int YEAR_W      = 14;
	localparam int DAY_W       = 5;
	localparam int MONTH_W     = 4;
	localparam int AMOUNT_W    = 32;
	localparam int OUT_COUNT_W = 32;
	localparam int STATUS_W    = 2;

	localparam logic [ADDR_W-1:0] LAST_ENTRY = ADDR_W'(TABLE_DEPTH - 1);
	localparam logic [ADDR_W-1:0] DEPTH_ADDR = ADDR_W'(TABLE_DEPTH);

	localparam logic [YEAR_W-1:0] YEAR_RESET = YEAR_W'(2000);

	// Inverse of 25 modulo 2^14, and the largest product that marks a multiple of 25.
	localparam logic [YEAR_W-1:0] INV25_MOD   = YEAR_W'(7209);
	localparam logic [YEAR_W-1:0] DIV25_LIMIT = YEAR_W'(655);

	// Operation codes.
	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_FETCH  = 1'b1;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_MONTH  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_DAY    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NEG_AMOUNT = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic clear;
		logic rec_finish;
		logic scan;
	} dcdt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
		logic scan_stop;
	} dcdt_sts_t;

	// Gregorian leap rule. A multiple of 25 is detected by multiplying with the
	// modular inverse of 25: exactly the multiples land in the lowest range.
	function automatic logic is_leap(input logic [YEAR_W-1:0] year);
		logic [YEAR_W-1:0] prod;
		logic              div4;
		logic              div16;
		logic              div25;
		prod  = year * INV25_MOD;
		div4  = (year[1:0] == 2'd0);
		div16 = (year[3:0] == 4'd0);
		div25 = (prod <= DIV25_LIMIT);
		return (div4 && !div25) || (div16 && div25);
	endfunction

	// Length of a month numbered 1 to 12; zero for any other number.
	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
		input logic leap);
		logic [DAY_W-1:0] len;
		unique case (month)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                       len = leap ? 5'd29 : 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

endpackage

>>> sv/dcdt_ctrl.sv
module dcdt_ctrl
	import dcdt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      op,
	input  dcdt_sts_t sts,
	output dcdt_cmd_t cmd,
	output logic      busy
);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_RECORD,
		S_SCAN
	} state_t;

	state_t state_q;
	logic   busy_q;

	// Command decode from the current state.
	always_comb begin
		cmd            = '0;
		cmd.accept     = (state_q == S_IDLE) && start;
		cmd.clear      = (state_q == S_CLEAR);
		cmd.rec_finish = (state_q == S_RECORD);
		cmd.scan       = (state_q == S_SCAN);
	end

	// State register and busy flag; reset starts the clearing sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			busy_q  <= 1'b1;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (sts.clear_last) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= (op == OP_RECORD) ? S_RECORD : S_SCAN;
						busy_q  <= 1'b1;
					end
				end
				S_RECORD: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
				S_SCAN: begin
					if (sts.scan_stop) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;

	// An accepted item always raises busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && start) |=> busy_q)
		else $error("busy not raised after an accepted item");

	// The record state always returns to idle in the next cycle.
	a_record_short: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RECORD) |=> (state_q == S_IDLE))
		else $error("record did not return to idle");

	// No item can be taken while the table is being cleared.
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> busy_q)
		else $error("busy low during clearing sweep");

endmodule

>>> sv/dcdt_datapath.sv
module dcdt_datapath
	import dcdt_pkg::*;
#(
	parameter int COUNT_WIDTH = 32
)(
	input  logic                   clk,
	input  logic                   arst_n,
	input  dcdt_cmd_t              cmd,
	output dcdt_sts_t              sts,
	input  logic                   cfg_write,
	input  logic [YEAR_W-1:0]      cfg_data,
	input  logic                   op,
	input  logic [DAY_W-1:0]       day_in,
	input  logic [MONTH_W-1:0]     month_in,
	input  logic [AMOUNT_W-1:0]    amount_in,
	output logic                   done,
	output logic [STATUS_W-1:0]    status,
	output logic [DAY_W-1:0]       out_day,
	output logic [MONTH_W-1:0]     out_month,
	output logic [OUT_COUNT_W-1:0] out_count,
	output logic                   scan_done
);

	localparam int SUM_W = ((COUNT_WIDTH > AMOUNT_W - 1) ? COUNT_WIDTH : AMOUNT_W - 1) + 1;

	logic [COUNT_WIDTH-1:0] mem [TABLE_DEPTH];
	logic [COUNT_WIDTH-1:0] rd_q;

	logic                   leap_q;
	logic [ADDR_W-1:0]      clr_addr_q;
	logic [ADDR_W-1:0]      cursor_q;
	logic [ADDR_W-1:0]      scan_addr_q;
	logic [ADDR_W-1:0]      rec_addr_q;
	logic [STATUS_W-1:0]    rec_status_q;
	logic [AMOUNT_W-2:0]    amount_q;

	logic                   done_q;
	logic [STATUS_W-1:0]    status_q;
	logic [DAY_W-1:0]       out_day_q;
	logic [MONTH_W-1:0]     out_month_q;
	logic [OUT_COUNT_W-1:0] out_count_q;
	logic                   scan_done_q;

	logic [DAY_W-1:0]       in_len;
	logic [STATUS_W-1:0]    in_status;
	logic [ADDR_W-1:0]      in_addr;
	logic [ADDR_W-1:0]      scan_next;
	logic [ADDR_W-1:0]      rd_addr;
	logic                   rd_en;
	logic [ADDR_W-1:0]      wr_addr;
	logic [COUNT_WIDTH-1:0] wr_data;
	logic                   wr_en;
	logic [SUM_W-1:0]       sum;
	logic [COUNT_WIDTH-1:0] sat_sum;
	logic [MONTH_W-1:0]     scan_month;
	logic                   scan_pos_ok;
	logic                   scan_hit;
	logic                   scan_stop;

	// Leap flag follows the calendar year register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leap_q <= is_leap(YEAR_RESET);
		end else if (cfg_write) begin
			leap_q <= is_leap(cfg_data);
		end
	end

	// Checks of an incoming record, in priority order.
	always_comb begin
		in_len = month_days(month_in, leap_q);
		priority if (month_in < 4'd1 || month_in > 4'd12) begin
			in_status = ST_BAD_MONTH;
		end else if (day_in == '0 || day_in > in_len) begin
			in_status = ST_BAD_DAY;
		end else if (amount_in[AMOUNT_W-1]) begin
			in_status = ST_NEG_AMOUNT;
		end else begin
			in_status = ST_OK;
		end
	end

	assign in_addr = {month_in - 4'd1, day_in - 5'd1};

	// Saturating add for the read-modify-write of a record.
	assign sum     = SUM_W'(rd_q) + SUM_W'(amount_q);
	assign sat_sum = (|sum[SUM_W-1:COUNT_WIDTH]) ? '1 : sum[COUNT_WIDTH-1:0];

	// Scan check on the entry whose data has just been read.
	assign scan_month  = scan_addr_q[ADDR_W-1:DAY_W] + 4'd1;
	assign scan_pos_ok = scan_addr_q[DAY_W-1:0] < month_days(scan_month, leap_q);
	assign scan_hit    = scan_pos_ok && (rd_q != '0);
	assign scan_stop   = scan_hit || (scan_addr_q >= LAST_ENTRY);
	assign scan_next   = scan_addr_q + 9'd1;

	// Memory port selection.
	always_comb begin
		if (cmd.scan) begin
			rd_addr = scan_next;
		end else if (op == OP_RECORD) begin
			rd_addr = in_addr;
		end else begin
			rd_addr = cursor_q;
		end
		rd_en = (cmd.accept || cmd.scan) && (rd_addr < DEPTH_ADDR);

		if (cmd.clear) begin
			wr_addr = clr_addr_q;
			wr_data = '0;
			wr_en   = 1'b1;
		end else begin
			wr_addr = rec_addr_q;
			wr_data = sat_sum;
			wr_en   = cmd.rec_finish && (rec_status_q == ST_OK);
		end
	end

	// Count table with a registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Clearing sweep address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear) begin
			clr_addr_q <= clr_addr_q + 9'd1;
		end
	end

	// Captured record fields and scan position.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rec_addr_q   <= in_addr;
			rec_status_q <= in_status;
			amount_q     <= amount_in[AMOUNT_W-2:0];
			scan_addr_q  <= cursor_q;
		end else if (cmd.scan) begin
			scan_addr_q  <= scan_next;
		end
	end

	// Scan cursor moves past each found day and rewinds at the end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
		end else if (cmd.scan && scan_hit) begin
			cursor_q <= scan_next;
		end else if (cmd.scan && scan_stop) begin
			cursor_q <= '0;
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.rec_finish || (cmd.scan && scan_stop);
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (cmd.rec_finish) begin
			status_q    <= rec_status_q;
			out_day_q   <= '0;
			out_month_q <= '0;
			out_count_q <= '0;
			scan_done_q <= 1'b0;
		end else if (cmd.scan && scan_hit) begin
			status_q    <= ST_OK;
			out_day_q   <= scan_addr_q[DAY_W-1:0] + 5'd1;
			out_month_q <= scan_month;
			out_count_q <= OUT_COUNT_W'(rd_q);
			scan_done_q <= 1'b0;
		end else if (cmd.scan && scan_stop) begin
			status_q    <= ST_OK;
			out_day_q   <= '0;
			out_month_q <= '0;
			out_count_q <= '0;
			scan_done_q <= 1'b1;
		end
	end

	assign sts.clear_last = (clr_addr_q == LAST_ENTRY);
	assign sts.scan_stop  = scan_stop;

	assign done      = done_q;
	assign status    = status_q;
	assign out_day   = out_day_q;
	assign out_month = out_month_q;
	assign out_count = out_count_q;
	assign scan_done = scan_done_q;

	// A finished scan always leaves the cursor at the first day.
	a_done_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && scan_done_q) |-> (cursor_q == '0))
		else $error("cursor not rewound after a finished scan");

	// The clearing sweep never overlaps item work.
	a_clear_alone: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> !(cmd.accept || cmd.scan || cmd.rec_finish))
		else $error("item command during clearing sweep");

	// A rejected record never writes the table.
	a_reject_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rec_finish && rec_status_q != ST_OK) |-> !wr_en)
		else $error("rejected record wrote the table");

endmodule

>>> sv/date_checked_day_count_table_top.sv
// Channel  | Signals                                       | Transfer
// ---------+-----------------------------------------------+-------------------------------
// item in  | op, day_in, month_in, amount_in               | start high while busy is low
// result   | status, out_day, out_month, out_count,        | done high for one cycle
//          | scan_done                                     |
// config   | cfg_data (calendar year)                      | cfg_write high
//
// A record reads the day's count when accepted, then writes the saturated sum.
// A fetch scans from the cursor to the next nonzero day, or to the last table entry;
// the scan reads one entry per cycle from the single read port.
// After reset the table is cleared one entry per cycle, and busy stays high for the sweep.
// The result is shown for exactly one cycle; the receiver cannot stall it.
module date_checked_day_count_table_top
	import dcdt_pkg::*;
#(
	parameter int COUNT_WIDTH = 32
)(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   op,
	input  logic [DAY_W-1:0]       day_in,
	input  logic [MONTH_W-1:0]     month_in,
	input  logic [AMOUNT_W-1:0]    amount_in,
	input  logic                   cfg_write,
	input  logic [YEAR_W-1:0]      cfg_data,
	output logic                   done,
	output logic [STATUS_W-1:0]    status,
	output logic [DAY_W-1:0]       out_day,
	output logic [MONTH_W-1:0]     out_month,
	output logic [OUT_COUNT_W-1:0] out_count,
	output logic                   scan_done
);

	dcdt_cmd_t cmd;
	dcdt_sts_t sts;

	// Sequencing of clear, record and scan.
	dcdt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Count table, checks and result registers.
	dcdt_datapath #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.op        (op),
		.day_in    (day_in),
		.month_in  (month_in),
		.amount_in (amount_in),
		.done      (done),
		.status    (status),
		.out_day   (out_day),
		.out_month (out_month),
		.out_count (out_count),
		.scan_done (scan_done)
	);

endmodule
